// ===== hw/rtl/mau_pkg.sv =====
// Shared types, operation codes and controller commands for the modular arithmetic unit.
`timescale 1ns / 1ps
package mau_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DATA_W);
	localparam logic [DATA_W-1:0] MODULUS_RESET = DATA_W'(2);

	// operation field codes
	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_INV = 2'd3;

	// datapath commands
	localparam logic [4:0] DP_NOP       = 5'd0;
	localparam logic [4:0] DP_LOAD      = 5'd1;
	localparam logic [4:0] DP_ZERO      = 5'd2;
	localparam logic [4:0] DP_DIV_A     = 5'd3;
	localparam logic [4:0] DP_DIV_STEP  = 5'd4;
	localparam logic [4:0] DP_SAVE_A    = 5'd5;
	localparam logic [4:0] DP_SAVE_B    = 5'd6;
	localparam logic [4:0] DP_ADD       = 5'd7;
	localparam logic [4:0] DP_SUB       = 5'd8;
	localparam logic [4:0] DP_MUL_START = 5'd9;
	localparam logic [4:0] DP_MUL_DBL   = 5'd10;
	localparam logic [4:0] DP_MUL_ADD   = 5'd11;
	localparam logic [4:0] DP_MUL_DONE  = 5'd12;
	localparam logic [4:0] DP_FAIL      = 5'd13;
	localparam logic [4:0] DP_INV_INIT  = 5'd14;
	localparam logic [4:0] DP_INV_DONE  = 5'd15;
	localparam logic [4:0] DP_EUC_DIV   = 5'd16;
	localparam logic [4:0] DP_EUC_MUL   = 5'd17;
	localparam logic [4:0] DP_EUC_UPD   = 5'd18;
	localparam logic [4:0] DP_EMIT      = 5'd19;

	// APB register index
	localparam logic REG_MODULUS = 1'b0;

	typedef struct packed {
		logic [1:0]        func;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
	} mau_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              status;
	} mau_out_t;

	typedef struct packed {
		logic [4:0] op;
	} mau_cmd_t;

	typedef struct packed {
		logic       m_small;
		logic       a_zero;
		logic       r1_zero;
		logic       cnt_last;
		logic [1:0] func;
	} mau_stat_t;

endpackage

// ===== hw/rtl/mau_datapath.sv =====
// Datapath: operand registers, shared restoring divider, shift-and-add modular multiplier, Euclid state.
`timescale 1ns / 1ps
module mau_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mau_pkg::mau_cmd_t        cmd,
	input  mau_pkg::mau_in_t         in_data,
	input  logic [mau_pkg::DATA_W-1:0] modulus,
	output mau_pkg::mau_stat_t       stat,
	output mau_pkg::mau_out_t        out_data
);
	import mau_pkg::*;

	logic [1:0]        func_q;
	logic [DATA_W-1:0] opa_q, opb_q, a_q, b_q;
	logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
	logic [DATA_W-1:0] acc_q, mx_q, my_q;
	logic [DATA_W-1:0] r0_q, r1_q, t0_q, t1_q;
	logic [DATA_W-1:0] res_q;
	logic              st_q;
	logic [CNT_W-1:0]  cnt_q;
	mau_out_t          out_q;

	logic [DATA_W:0]   part, dsum, asum, psum;
	logic              qbit;
	logic [DATA_W-1:0] part_rem, dbl_mod, add_mod, pair_add, sub_res, tn, qm;

	// one restoring division step
	always_comb begin
		part     = {rem_q, quo_q[DATA_W-1]};
		qbit     = (part >= {1'b0, dvs_q});
		part_rem = qbit ? DATA_W'(part - {1'b0, dvs_q}) : part[DATA_W-1:0];
	end

	// modular doubling and conditional add for the multiplier
	always_comb begin
		dsum    = {1'b0, acc_q} + {1'b0, acc_q};
		dbl_mod = (dsum >= {1'b0, modulus}) ? DATA_W'(dsum - {1'b0, modulus})
			: dsum[DATA_W-1:0];
		asum    = {1'b0, acc_q} + {1'b0, mx_q};
		add_mod = (asum >= {1'b0, modulus}) ? DATA_W'(asum - {1'b0, modulus})
			: asum[DATA_W-1:0];
	end

	// plain add and subtract of the reduced operands, Euclid t update and quotient fold
	always_comb begin
		psum     = {1'b0, a_q} + {1'b0, b_q};
		pair_add = (psum >= {1'b0, modulus}) ? DATA_W'(psum - {1'b0, modulus})
			: psum[DATA_W-1:0];
		sub_res  = (a_q >= b_q) ? (a_q - b_q) : (a_q - b_q + modulus);
		tn       = (t0_q >= acc_q) ? (t0_q - acc_q) : (t0_q - acc_q + modulus);
		qm       = (quo_q == modulus) ? '0 : quo_q;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				func_q <= in_data.func;
				opa_q  <= in_data.operand_a;
				opb_q  <= in_data.operand_b;
			end
			DP_ZERO: begin
				res_q <= '0;
				st_q  <= (func_q == FUNC_INV);
			end
			DP_DIV_A: begin
				rem_q <= '0;
				quo_q <= opa_q;
				dvs_q <= modulus;
			end
			DP_DIV_STEP: begin
				rem_q <= part_rem;
				quo_q <= {quo_q[DATA_W-2:0], qbit};
			end
			DP_SAVE_A: begin
				a_q   <= rem_q;
				rem_q <= '0;
				quo_q <= opb_q;
				dvs_q <= modulus;
			end
			DP_SAVE_B: b_q <= rem_q;
			DP_ADD: begin
				res_q <= pair_add;
				st_q  <= 1'b0;
			end
			DP_SUB: begin
				res_q <= sub_res;
				st_q  <= 1'b0;
			end
			DP_MUL_START: begin
				acc_q <= '0;
				mx_q  <= a_q;
				my_q  <= b_q;
			end
			DP_MUL_DBL: acc_q <= dbl_mod;
			DP_MUL_ADD: begin
				if (my_q[DATA_W-1]) begin
					acc_q <= add_mod;
				end
				my_q <= {my_q[DATA_W-2:0], 1'b0};
			end
			DP_MUL_DONE: begin
				res_q <= acc_q;
				st_q  <= 1'b0;
			end
			DP_FAIL: begin
				res_q <= '0;
				st_q  <= 1'b1;
			end
			DP_INV_INIT: begin
				r0_q <= modulus;
				r1_q <= a_q;
				t0_q <= '0;
				t1_q <= DATA_W'(1);
			end
			DP_INV_DONE: begin
				res_q <= (r0_q == DATA_W'(1)) ? t0_q : '0;
				st_q  <= (r0_q != DATA_W'(1));
			end
			DP_EUC_DIV: begin
				rem_q <= '0;
				quo_q <= r0_q;
				dvs_q <= r1_q;
			end
			DP_EUC_MUL: begin
				acc_q <= '0;
				mx_q  <= qm;
				my_q  <= t1_q;
			end
			DP_EUC_UPD: begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				t0_q <= t1_q;
				t1_q <= tn;
			end
			DP_EMIT: begin
				out_q.result <= res_q;
				out_q.status <= st_q;
			end
			default: ;
		endcase
	end

	// step counter for division and multiplication
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.op)
				DP_DIV_A, DP_SAVE_A, DP_EUC_DIV, DP_MUL_START, DP_EUC_MUL: begin
					cnt_q <= CNT_W'(DATA_W - 1);
				end
				DP_DIV_STEP, DP_MUL_ADD: cnt_q <= cnt_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	assign stat.m_small  = (modulus < DATA_W'(2));
	assign stat.a_zero   = (a_q == '0);
	assign stat.r1_zero  = (r1_q == '0);
	assign stat.cnt_last = (cnt_q == '0);
	assign stat.func     = func_q;
	assign out_data      = out_q;

endmodule

// ===== hw/rtl/mau_ctrl.sv =====
// Controller: sequences operand reduction, the operation and the Euclid loop; owns the handshakes.
`timescale 1ns / 1ps
module mau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mau_pkg::mau_stat_t  stat,
	output mau_pkg::mau_cmd_t   cmd
);
	import mau_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_DIVA  = 4'd2;
	localparam logic [3:0] S_SAVEA = 4'd3;
	localparam logic [3:0] S_DIVB  = 4'd4;
	localparam logic [3:0] S_SAVEB = 4'd5;
	localparam logic [3:0] S_EXEC  = 4'd6;
	localparam logic [3:0] S_MDBL  = 4'd7;
	localparam logic [3:0] S_MADD  = 4'd8;
	localparam logic [3:0] S_MEND  = 4'd9;
	localparam logic [3:0] S_ETEST = 4'd10;
	localparam logic [3:0] S_EDIV  = 4'd11;
	localparam logic [3:0] S_EQ    = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;

	logic [3:0] state_q, state_d;
	logic       ov_q;
	logic       accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = ov_q;

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.op  = DP_NOP;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op  = DP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.m_small) begin
					cmd.op  = DP_ZERO;
					state_d = S_EMIT;
				end else begin
					cmd.op  = DP_DIV_A;
					state_d = S_DIVA;
				end
			end
			S_DIVA: begin
				cmd.op = DP_DIV_STEP;
				if (stat.cnt_last) state_d = S_SAVEA;
			end
			S_SAVEA: begin
				cmd.op  = DP_SAVE_A;
				state_d = S_DIVB;
			end
			S_DIVB: begin
				cmd.op = DP_DIV_STEP;
				if (stat.cnt_last) state_d = S_SAVEB;
			end
			S_SAVEB: begin
				cmd.op  = DP_SAVE_B;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				case (stat.func)
					FUNC_ADD: begin
						cmd.op  = DP_ADD;
						state_d = S_EMIT;
					end
					FUNC_SUB: begin
						cmd.op  = DP_SUB;
						state_d = S_EMIT;
					end
					FUNC_MUL: begin
						cmd.op  = DP_MUL_START;
						state_d = S_MDBL;
					end
					default: begin
						if (stat.a_zero) begin
							cmd.op  = DP_FAIL;
							state_d = S_EMIT;
						end else begin
							cmd.op  = DP_INV_INIT;
							state_d = S_ETEST;
						end
					end
				endcase
			end
			S_MDBL: begin
				cmd.op  = DP_MUL_DBL;
				state_d = S_MADD;
			end
			S_MADD: begin
				cmd.op  = DP_MUL_ADD;
				state_d = stat.cnt_last ? S_MEND : S_MDBL;
			end
			S_MEND: begin
				if (stat.func == FUNC_INV) begin
					cmd.op  = DP_EUC_UPD;
					state_d = S_ETEST;
				end else begin
					cmd.op  = DP_MUL_DONE;
					state_d = S_EMIT;
				end
			end
			S_ETEST: begin
				if (stat.r1_zero) begin
					cmd.op  = DP_INV_DONE;
					state_d = S_EMIT;
				end else begin
					cmd.op  = DP_EUC_DIV;
					state_d = S_EDIV;
				end
			end
			S_EDIV: begin
				cmd.op = DP_DIV_STEP;
				if (stat.cnt_last) state_d = S_EQ;
			end
			S_EQ: begin
				cmd.op  = DP_EUC_MUL;
				state_d = S_MDBL;
			end
			S_EMIT: begin
				if (!ov_q || out_ready) begin
					cmd.op  = DP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the output slot until the result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.op == DP_EMIT) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_EMIT) |-> (!ov_q || out_ready))
		else $error("result emitted over a pending result");

	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CHK))
		else $error("accepted item not checked next cycle");

	a_ov_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(cmd.op == DP_EMIT))
		else $error("output valid raised without emit");

	a_mend_after_madd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MEND) |-> $past(state_q == S_MADD))
		else $error("multiply finished without its last step");

endmodule

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// Top level of the modular arithmetic unit: APB modulus register, controller and datapath.
`timescale 1ns / 1ps
// Usage:
//   Program the modulus over the APB port (register at byte address 0, reset value 2);
//   write it only while the unit is idle.
//   Send items on in_valid/in_ready: func (0 add, 1 subtract, 2 multiply, 3 inverse),
//   operand_a, operand_b. One result per item leaves on out_valid/out_ready: result in
//   [0, modulus) and status (1 when no inverse exists). A modulus below 2 gives result 0
//   and goes to the output register without the operand reductions.
//   Otherwise every operation first reduces both operands in the shared restoring divider;
//   multiply then runs the shift-and-add multiplier, one doubling and one add step per bit.
//   Inverse runs up to about 47 Euclid steps, each one division, one multiply and an
//   update of the remainders and coefficients.
//   One item is in work at a time; the next item is accepted once a result is ready,
//   even while that result still waits for the receiver in the output register.
//   When the receiver stalls, the finished result is held and the unit waits.
//   Reset clears the controller, drops out_valid and sets the modulus to 2.
module modular_arithmetic_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  mau_pkg::mau_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output mau_pkg::mau_out_t          out_data
);
	import mau_pkg::*;

	logic [DATA_W-1:0] modulus_q;
	mau_cmd_t          cmd;
	mau_stat_t         stat;

	assign pready = 1'b1;

	// modulus register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS)) begin
			modulus_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_MODULUS) ? modulus_q : '0;

	mau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mau_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.modulus  (modulus_q),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule
